>>> hw/rtl/center_roi_auto_exposure_macros.svh
// ----------------------------------------------------------------------------
// center_roi_auto_exposure assertion macros
// shared concurrent assertion forms for the auto-exposure block
// ----------------------------------------------------------------------------
`ifndef CENTER_ROI_AUTO_EXPOSURE_MACROS_SVH
`define CENTER_ROI_AUTO_EXPOSURE_MACROS_SVH

// same-cycle implication, disabled in reset
`define CRA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define CRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cra_pkg.sv
// ----------------------------------------------------------------------------
// cra_pkg
// types, constants and helpers shared by the auto-exposure block
// ----------------------------------------------------------------------------
package cra_pkg;

  // field widths
  localparam int COORD_W  = 8;
  localparam int PIX_W    = 8;
  localparam int EXP_W    = 16;
  localparam int SUM_W    = 24;
  localparam int COUNT_W  = 17;
  localparam int STEP_W   = 10;
  localparam int ERR_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;
  localparam int COORD_SPAN = 2 ** COORD_W;

  // parameter defaults
  localparam int ROW_PITCH_DEF   = 2;
  localparam int COL_PITCH_DEF   = 2;
  localparam int EXP_MIN_DEF     = 1;
  localparam int EXP_MAX_DEF     = 4095;
  localparam int EXP_RESET_DEF   = 300;
  localparam int QUEUE_DEPTH_DEF = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_LEFT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_TOP        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROI_HEIGHT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_INTERVAL = 3'd7;

  // operation codes
  localparam logic OP_PIXEL  = 1'b0;
  localparam logic OP_MANUAL = 1'b1;

  typedef struct packed {
    logic [7:0]        roi_left;
    logic [7:0]        roi_top;
    logic [7:0]        roi_width;
    logic [7:0]        roi_height;
    logic [7:0]        target_level;
    logic [7:0]        dead_band;
    logic [STEP_W-1:0] max_step;
    logic [7:0]        frame_interval;
  } cfg_t;

  typedef struct packed {
    logic               operation;
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_col;
    logic [PIX_W-1:0]   pixel_value;
    logic               frame_end;
    logic [EXP_W-1:0]   manual_exposure;
  } item_t;

  // work handed from the front to the back
  typedef struct packed {
    logic               manual;
    logic               evaluate;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
    logic [EXP_W-1:0]   manual_exposure;
  } job_t;

  typedef struct packed {
    logic [EXP_W-1:0]        exposure_now;
    logic [PIX_W-1:0]        mean_level;
    logic signed [ERR_W-1:0] level_error;
    logic                    evaluated;
    logic                    exposure_changed;
  } result_t;

  // bit i set when offset i is a multiple of step
  function automatic logic [COORD_SPAN-1:0] step_table(input int step);
    logic [COORD_SPAN-1:0] t;
    int ph;
    t  = '0;
    ph = 0;
    for (int i = 0; i < COORD_SPAN; i++) begin
      t[i] = (ph == 0);
      ph   = (ph >= step - 1) ? 0 : ph + 1;
    end
    return t;
  endfunction

endpackage

>>> hw/rtl/center_roi_auto_exposure.sv
// ----------------------------------------------------------------------------
// center_roi_auto_exposure
// centre-region mean metering with proportional exposure control
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       pixel or manual-set item
// m_*       out  m_tvalid / m_tready       one result per frame end or manual set
// cfg_*     in   cfg_valid / cfg_ready     register index and write data
//
// pixels are taken one per cycle; only frame-end and manual items go into the
// job queue (QUEUE_DEPTH entries), and s_tready drops while it is full.
// the back takes one job at a time, and an evaluated frame needs the mean
// from the 8-step shift-subtract divider, one quotient bit per cycle; an empty
// region or a mean that saturates skips the divider.
// rst is synchronous; it resets state, counters and config, not data registers.
// a stalled m_tready holds the result register; the front keeps accepting
// until the queue fills.
// ----------------------------------------------------------------------------
module center_roi_auto_exposure #(
  parameter int ROW_PITCH   = cra_pkg::ROW_PITCH_DEF,
  parameter int COL_PITCH   = cra_pkg::COL_PITCH_DEF,
  parameter int EXP_MIN     = cra_pkg::EXP_MIN_DEF,
  parameter int EXP_MAX     = cra_pkg::EXP_MAX_DEF,
  parameter int EXP_RESET   = cra_pkg::EXP_RESET_DEF,
  parameter int QUEUE_DEPTH = cra_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // pixel_row[7:0], pixel_col[15:8], pixel_value[23:16], manual_exposure[39:24]
  input  logic [cra_pkg::IN_DATA_W-1:0]       s_tdata,
  // operation
  input  logic                                s_tuser,
  // frame_end
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // exposure_now[15:0], mean_level[23:16], level_error[32:24], zeros above
  output logic [cra_pkg::OUT_DATA_W-1:0]      m_tdata,
  // evaluated[0], exposure_changed[1]
  output logic [cra_pkg::OUT_USER_W-1:0]      m_tuser,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cra_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cra_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cra_pkg::*;

  cfg_t    cfg;
  item_t   item;
  job_t    push_job;
  job_t    pop_job;
  result_t res;
  logic    push_valid;
  logic    push_ready;
  logic    pop_valid;
  logic    pop_ready;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.roi_left       <= 8'd64;
      cfg.roi_top        <= 8'd40;
      cfg.roi_width      <= 8'd60;
      cfg.roi_height     <= 8'd40;
      cfg.target_level   <= 8'd128;
      cfg.dead_band      <= 8'd8;
      cfg.max_step       <= 10'd20;
      cfg.frame_interval <= 8'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROI_LEFT:       cfg.roi_left       <= cfg_data[7:0];
        CFG_ROI_TOP:        cfg.roi_top        <= cfg_data[7:0];
        CFG_ROI_WIDTH:      cfg.roi_width      <= cfg_data[7:0];
        CFG_ROI_HEIGHT:     cfg.roi_height     <= cfg_data[7:0];
        CFG_TARGET_LEVEL:   cfg.target_level   <= cfg_data[7:0];
        CFG_DEAD_BAND:      cfg.dead_band      <= cfg_data[7:0];
        CFG_MAX_STEP:       cfg.max_step       <= cfg_data;
        CFG_FRAME_INTERVAL: cfg.frame_interval <= cfg_data[7:0];
        default:            cfg.roi_left       <= cfg.roi_left;
      endcase
    end
  end

  // unpack the input transfer
  always_comb begin
    item.operation       = s_tuser;
    item.pixel_row       = s_tdata[7:0];
    item.pixel_col       = s_tdata[15:8];
    item.pixel_value     = s_tdata[23:16];
    item.frame_end       = s_tlast;
    item.manual_exposure = s_tdata[39:24];
  end

  cra_front #(
    .ROW_PITCH (ROW_PITCH),
    .COL_PITCH (COL_PITCH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_item    (item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  cra_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  cra_back #(
    .EXP_MIN   (EXP_MIN),
    .EXP_MAX   (EXP_MAX),
    .EXP_RESET (EXP_RESET)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (pop_valid),
    .job_ready (pop_ready),
    .job       (pop_job),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  // pack the output transfer
  assign m_tdata = {7'b0, res.level_error, res.mean_level, res.exposure_now};
  assign m_tuser = {res.exposure_changed, res.evaluated};

endmodule

>>> hw/rtl/cra_front.sv
// ----------------------------------------------------------------------------
// cra_front
// region sampling, sum and count per frame, frame pacing; emits jobs
// ----------------------------------------------------------------------------
module cra_front #(
  parameter int ROW_PITCH = cra_pkg::ROW_PITCH_DEF,
  parameter int COL_PITCH = cra_pkg::COL_PITCH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  cra_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  cra_pkg::item_t in_item,
  output logic          push_valid,
  input  logic          push_ready,
  output cra_pkg::job_t push_job
);
  import cra_pkg::*;

  localparam logic [COORD_SPAN-1:0] ROW_HITS = step_table(ROW_PITCH);
  localparam logic [COORD_SPAN-1:0] COL_HITS = step_table(COL_PITCH);

  logic [SUM_W-1:0]   region_sum;
  logic [COUNT_W-1:0] region_count;
  logic [7:0]         frame_counter;

  logic [SUM_W-1:0]   sum_next;
  logic [COUNT_W-1:0] count_next;
  logic [SUM_W:0]     sum_wide;
  logic [COORD_W:0]   row_end;
  logic [COORD_W:0]   col_first;
  logic [COORD_W:0]   col_end;
  logic [COORD_W:0]   col_off;
  logic [COORD_W-1:0] row_off;
  logic               in_rows;
  logic               in_cols;
  logic               sampled;
  logic [7:0]         fc_inc;
  logic               eval_now;
  logic               accept;

  assign in_ready = push_ready;
  assign accept   = in_valid & in_ready;

  // region membership with decimation
  always_comb begin
    row_end   = {1'b0, cfg.roi_top} + {1'b0, cfg.roi_height};
    in_rows   = ({1'b0, in_item.pixel_row} >= {1'b0, cfg.roi_top}) &&
                ({1'b0, in_item.pixel_row} < row_end);
    row_off   = in_item.pixel_row - cfg.roi_top;
    col_first = {1'b0, cfg.roi_left} + {{COORD_W{1'b0}}, in_item.pixel_row[0]};
    col_end   = {1'b0, cfg.roi_left} + {1'b0, cfg.roi_width};
    in_cols   = ({1'b0, in_item.pixel_col} >= col_first) &&
                ({1'b0, in_item.pixel_col} < col_end);
    col_off   = {1'b0, in_item.pixel_col} - col_first;
    sampled   = in_rows && ROW_HITS[row_off] && in_cols &&
                COL_HITS[col_off[COORD_W-1:0]];
  end

  // saturating accumulate
  always_comb begin
    sum_wide   = {1'b0, region_sum} + {{(SUM_W + 1 - PIX_W){1'b0}}, in_item.pixel_value};
    sum_next   = region_sum;
    count_next = region_count;
    if (sampled) begin
      sum_next   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
      count_next = (region_count == {COUNT_W{1'b1}}) ? region_count
                                                      : region_count + 1'b1;
    end
  end

  // frame pacing
  assign fc_inc   = frame_counter + 8'd1;
  assign eval_now = (fc_inc >= cfg.frame_interval);

  // job toward the back
  always_comb begin
    push_valid               = accept && ((in_item.operation == OP_MANUAL) ||
                                          in_item.frame_end);
    push_job.manual          = (in_item.operation == OP_MANUAL);
    push_job.evaluate        = (in_item.operation == OP_PIXEL) && eval_now;
    push_job.sum             = sum_next;
    push_job.count           = count_next;
    push_job.manual_exposure = in_item.manual_exposure;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_sum    <= '0;
      region_count  <= '0;
      frame_counter <= '0;
    end else if (accept && (in_item.operation == OP_PIXEL)) begin
      if (in_item.frame_end) begin
        region_sum    <= '0;
        region_count  <= '0;
        frame_counter <= eval_now ? 8'd0 : fc_inc;
      end else begin
        region_sum    <= sum_next;
        region_count  <= count_next;
      end
    end
  end

endmodule

>>> hw/rtl/cra_queue.sv
// ----------------------------------------------------------------------------
// cra_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module cra_queue #(
  parameter int DEPTH = cra_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  cra_pkg::job_t push_job,
  output logic          pop_valid,
  input  logic          pop_ready,
  output cra_pkg::job_t pop_job
);
  import cra_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_job    = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> hw/rtl/cra_back.sv
// ----------------------------------------------------------------------------
// cra_back
// mean by shift-subtract divider, error, step limit and exposure update
// ----------------------------------------------------------------------------
`include "center_roi_auto_exposure_macros.svh"

module cra_back #(
  parameter int EXP_MIN   = cra_pkg::EXP_MIN_DEF,
  parameter int EXP_MAX   = cra_pkg::EXP_MAX_DEF,
  parameter int EXP_RESET = cra_pkg::EXP_RESET_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cra_pkg::cfg_t    cfg,
  input  logic             job_valid,
  output logic             job_ready,
  input  cra_pkg::job_t    job,
  output logic             res_valid,
  input  logic             res_ready,
  output cra_pkg::result_t res
);
  import cra_pkg::*;

  localparam int CLAMP_W = EXP_W + 2;
  localparam logic signed [CLAMP_W-1:0] MIN_S = CLAMP_W'(EXP_MIN);
  localparam logic signed [CLAMP_W-1:0] MAX_S = CLAMP_W'(EXP_MAX);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t             state;
  logic               is_manual;
  logic               is_eval;
  logic [EXP_W-1:0]   manual_val;
  logic [SUM_W-1:0]   rem;
  logic [SUM_W-1:0]   dsh;
  logic [PIX_W-1:0]   quotient;
  logic [2:0]         bit_cnt;
  logic [EXP_W-1:0]   exposure_value;

  logic               out_free;
  logic               load_out;
  logic               ge;
  logic               job_div;
  logic               job_sat;
  logic signed [9:0]  err;
  logic [8:0]         abs_err;
  logic               in_band;
  logic [STEP_W-1:0]  mag;
  logic [STEP_W-1:0]  step;
  logic signed [CLAMP_W-1:0] moved;
  logic [EXP_W-1:0]   exp_new;
  logic               changed;

  // lower limit first, then upper
  function automatic logic [EXP_W-1:0] clamp_exp(input logic signed [CLAMP_W-1:0] v);
    logic signed [CLAMP_W-1:0] t;
    t = v;
    if (t < MIN_S) t = MIN_S;
    if (t > MAX_S) t = MAX_S;
    return t[EXP_W-1:0];
  endfunction

  assign job_ready = (state == ST_IDLE);
  assign out_free  = !res_valid || res_ready;
  assign load_out  = (state == ST_DONE) && out_free;
  assign ge        = (rem >= dsh);

  // divider needed unless the region is empty or the mean saturates
  assign job_div = job.evaluate && !job.manual && (job.count != '0);
  assign job_sat = ({1'b0, job.sum} >= {job.count, 8'b0});

  // error, dead band, limited step
  always_comb begin
    err     = $signed({2'b00, quotient}) - $signed({2'b00, cfg.target_level});
    abs_err = err[9] ? 9'(-err) : err[8:0];
    in_band = (abs_err < {1'b0, cfg.dead_band});
    mag     = {3'b000, abs_err[8:2]};
    step    = (mag > cfg.max_step) ? cfg.max_step : mag;
    moved   = err[9] ? $signed({2'b00, exposure_value}) + $signed({8'b0, step})
                     : $signed({2'b00, exposure_value}) - $signed({8'b0, step});
    if (is_manual) begin
      exp_new = clamp_exp($signed({2'b00, manual_val}));
      changed = 1'b1;
    end else if (is_eval && !in_band) begin
      exp_new = clamp_exp(moved);
      changed = 1'b1;
    end else begin
      exp_new = exposure_value;
      changed = 1'b0;
    end
  end

  // sequencer and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      res_valid      <= 1'b0;
      exposure_value <= EXP_W'(EXP_RESET);
    end else begin
      if (load_out) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            is_manual  <= job.manual;
            is_eval    <= job.evaluate && !job.manual;
            manual_val <= job.manual_exposure;
            rem        <= job.sum;
            dsh        <= {job.count, 7'b0};
            bit_cnt    <= 3'd7;
            // a quotient of 256 or more saturates without dividing
            quotient   <= (job_div && job_sat) ? {PIX_W{1'b1}} : '0;
            state      <= (job_div && !job_sat) ? ST_DIV : ST_DONE;
          end
        end
        ST_DIV: begin
          if (ge) begin
            rem <= rem - dsh;
          end
          quotient <= {quotient[PIX_W-2:0], ge};
          dsh      <= dsh >> 1;
          bit_cnt  <= bit_cnt - 3'd1;
          if (bit_cnt == 3'd0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            exposure_value       <= exp_new;
            res.exposure_now     <= exp_new;
            res.mean_level       <= is_eval ? quotient : '0;
            res.level_error      <= is_eval ? err[ERR_W-1:0] : '0;
            res.evaluated        <= is_eval;
            res.exposure_changed <= changed;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `CRA_ASSERT_NEXT(a_exp_hold, clk, rst, !load_out, $stable(exposure_value), "exposure moved outside result load")
  `CRA_ASSERT_IMPL(a_div_range, clk, rst, state == ST_DIV, {1'b0, rem} < {dsh, 1'b0}, "divider remainder out of range")
  `CRA_ASSERT_IMPL(a_idle_zero, clk, rst, res_valid && !res.evaluated, (res.mean_level == '0) && (res.level_error == '0), "mean or error set without evaluation")
  `CRA_ASSERT_IMPL(a_exp_limit, clk, rst, res_valid && res.exposure_changed, 32'(res.exposure_now) <= 32'(EXP_MAX), "written exposure above upper limit")

endmodule
